// ===== rtl/csplit_pkg.sv =====
package csplit_pkg;

  // Sizing of the part buffer and of the kept part counter
  localparam int PART_BYTES = 64;
  localparam int MAX_PARTS  = 16;
  localparam int PB_AW      = $clog2(PART_BYTES);
  localparam int RAW_W      = $clog2(PART_BYTES + 1);
  localparam int KEPT_W     = $clog2(MAX_PARTS + 1);

  // Field widths fixed by the block's interface
  localparam int CFG_W      = 7;
  localparam int MAXP_W     = 5;
  localparam int PLIM_W     = 7;

  // Characters with a meaning to the splitter
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_PARTS  = 1'b0,
    CFG_PART_LIMIT = 1'b1
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // input transaction this cycle
    logic load_char;   // move buffered byte into the output register
    logic load_empty;  // present an empty-part result
    logic load_end;    // present the string end result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic is_close;    // current input byte closes a part
    logic byte_end;    // current input byte is the terminator
    logic keep;        // current part will be kept
    logic empty;       // current part trims to nothing
    logic is_end;      // part being emitted was closed by the terminator
    logic at_end;      // read pointer on last trimmed byte
    logic out_valid;
    logic out_free;    // output register can take a new result
  } stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== rtl/csplit_intf.sv =====
// Input channel: one string byte per transaction
interface csplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel: one result per transaction
interface csplit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       part_end;
  logic [3:0] part_number;
  logic       string_end;
  logic [4:0] part_count;
  logic       last;

  modport source (output valid, output out_char, output char_valid, output part_end,
                  output part_number, output string_end, output part_count,
                  output last, input ready);
  modport sink   (input valid, input out_char, input char_valid, input part_end,
                  input part_number, input string_end, input part_count,
                  input last, output ready);
endinterface

// ===== rtl/top_level_comma_splitter.sv =====
// Comma splitter: splits a zero-terminated byte string at commas that lie
// outside quotes and outside brackets, and emits each kept part trimmed.
// in_ch carries one string byte per transaction; byte 0 ends the string.
// out_ch carries one result per transaction: a part byte, an empty-part
// marker, or the string end result with the final part count. The last
// result caused by one input byte has last set.
// cfg_we/cfg_index/cfg_data write max_parts (index 0) and part_limit
// (index 1); write them only while the block is idle.
// Ordinary bytes are taken one per cycle while the block is idle and are stored
// in the part buffer while it has room. A closing byte starts emission: the
// first trimmed byte is read from the part buffer into a read register, and
// the results then follow one per cycle unless the receiver stalls.
// The string end result comes after the results of the final part.
// Reset (rst_n low, synchronous) clears the string state and sets
// max_parts to 16 and part_limit to 64; the buffer itself is not cleared.
// If the receiver stalls, the output register holds its result and part
// emission pauses; no byte is taken while a part is being emitted. Once
// only the last result waits, ordinary bytes are taken again, but a
// closing byte waits until that result has been taken.
module top_level_comma_splitter
  import csplit_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  csplit_in_if.sink          in_ch,
  csplit_out_if.source       out_ch,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cmd_t  cmd;
  stat_t st;

  csplit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  csplit_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_ch.valid),
    .in_byte     (in_ch.in_byte),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_char    (out_ch.out_char),
    .char_valid  (out_ch.char_valid),
    .part_end    (out_ch.part_end),
    .part_number (out_ch.part_number),
    .string_end  (out_ch.string_end),
    .part_count  (out_ch.part_count),
    .last        (out_ch.last),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

// ===== rtl/csplit_ctrl.sv =====
module csplit_ctrl
  import csplit_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t st,
  output logic  in_ready,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAR,
    S_EMPTY,
    S_END
  } state_t;

  state_t state_r, state_nxt;

  // Commands and next state
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        // a closing byte waits until the previous result has gone
        in_ready   = !(st.is_close && st.out_valid);
        cmd.accept = st.in_valid && in_ready;
        if (cmd.accept && st.is_close) begin
          if (st.keep && !st.empty) begin
            state_nxt = S_CHAR;
          end else if (st.keep) begin
            state_nxt = S_EMPTY;
          end else if (st.byte_end) begin
            state_nxt = S_END;
          end
        end
      end
      S_CHAR: begin
        cmd.load_char = st.out_free;
        if (st.out_free && st.at_end) begin
          state_nxt = st.is_end ? S_END : S_IDLE;
        end
      end
      S_EMPTY: begin
        cmd.load_empty = st.out_free;
        if (st.out_free) begin
          state_nxt = st.is_end ? S_END : S_IDLE;
        end
      end
      S_END: begin
        cmd.load_end = st.out_free;
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/csplit_dp.sv =====
module csplit_dp
  import csplit_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // input payload
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  // result channel
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_char,
  output logic              char_valid,
  output logic              part_end,
  output logic [3:0]        part_number,
  output logic              string_end,
  output logic [4:0]        part_count,
  output logic              last,
  // controller
  input  cmd_t              cmd,
  output stat_t             st
);

  // Configuration registers
  logic [MAXP_W-1:0] max_parts_r;
  logic [PLIM_W-1:0] part_limit_r;

  // Scanner state of the current string
  logic [RAW_W-1:0]  raw_len_r;
  logic              too_long_r;
  logic [7:0]        depth_r;
  logic [7:0]        quote_r;
  logic              esc_r;
  logic [KEPT_W-1:0] kept_r;
  logic              have_ns_r;
  logic [PB_AW-1:0]  first_r;
  logic [PB_AW-1:0]  last_ns_r;

  // Emission state
  logic [PB_AW-1:0]  rd_ptr_r;
  logic [PB_AW-1:0]  end_ptr_r;
  logic              is_end_r;
  logic [KEPT_W-1:0] num_r;
  logic [KEPT_W-1:0] cnt_r;

  // Part buffer
  logic [7:0]        mem [PART_BYTES];
  logic [7:0]        rdata_r;

  // Output register
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              char_valid_r;
  logic              part_end_r;
  logic [3:0]        part_number_r;
  logic              string_end_r;
  logic [4:0]        part_count_r;
  logic              last_r;

  logic              is_close, byte_end, keep, can_store, at_end, out_free;
  logic              mem_we, mem_re;
  logic [PB_AW-1:0]  mem_raddr;
  logic [PB_AW-1:0]  wpos;

  // Classification of the incoming byte and of the part in hand
  // (a part that fills the whole buffer is never kept)
  assign byte_end  = (in_byte == CH_NUL);
  assign is_close  = byte_end ||
                     ((quote_r == CH_NUL) && (in_byte == CH_COMMA) && (depth_r == 8'd0));
  assign keep      = !too_long_r && can_store &&
                     (8'(raw_len_r) < 8'(part_limit_r)) &&
                     (8'(kept_r) < 8'(max_parts_r)) &&
                     (kept_r < KEPT_W'(MAX_PARTS));
  assign can_store = (raw_len_r < RAW_W'(PART_BYTES));
  assign wpos      = raw_len_r[PB_AW-1:0];
  assign at_end    = (rd_ptr_r == end_ptr_r);
  assign out_free  = !out_valid_r || out_ready;

  assign st.in_valid  = in_valid;
  assign st.is_close  = is_close;
  assign st.byte_end  = byte_end;
  assign st.keep      = keep;
  assign st.empty     = !have_ns_r;
  assign st.is_end    = is_end_r;
  assign st.at_end    = at_end;
  assign st.out_valid = out_valid_r;
  assign st.out_free  = out_free;

  // Buffer access: write on a stored byte, read to prefetch the next byte
  assign mem_we    = cmd.accept && !is_close && can_store;
  assign mem_re    = (cmd.accept && is_close) || (cmd.load_char && !at_end);
  assign mem_raddr = cmd.accept ? first_r : rd_ptr_r + PB_AW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wpos] <= in_byte;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_parts_r  <= MAXP_W'(16);
      part_limit_r <= PLIM_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_PARTS:  max_parts_r  <= cfg_data[MAXP_W-1:0];
        CFG_PART_LIMIT: part_limit_r <= cfg_data[PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Scanner: quote, escape and bracket tracking, trim bounds, part closing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_len_r  <= '0;
      too_long_r <= 1'b0;
      depth_r    <= '0;
      quote_r    <= CH_NUL;
      esc_r      <= 1'b0;
      kept_r     <= '0;
      have_ns_r  <= 1'b0;
      is_end_r   <= 1'b0;
    end else if (cmd.accept) begin
      if (is_close) begin
        // latch what emission needs, then start a fresh part
        rd_ptr_r   <= first_r;
        end_ptr_r  <= last_ns_r;
        is_end_r   <= byte_end;
        num_r      <= kept_r;
        cnt_r      <= kept_r + KEPT_W'(keep);
        raw_len_r  <= '0;
        too_long_r <= 1'b0;
        have_ns_r  <= 1'b0;
        if (byte_end) begin
          depth_r <= '0;
          quote_r <= CH_NUL;
          esc_r   <= 1'b0;
          kept_r  <= '0;
        end else begin
          kept_r <= kept_r + KEPT_W'(keep);
        end
      end else begin
        if (quote_r != CH_NUL) begin
          if (esc_r) begin
            esc_r <= 1'b0;
          end else if (in_byte == CH_BSLASH) begin
            esc_r <= 1'b1;
          end else if (in_byte == quote_r) begin
            quote_r <= CH_NUL;
          end
        end else if ((in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE)) begin
          quote_r <= in_byte;
        end else if ((in_byte == CH_LPAREN) || (in_byte == CH_LBRACK) ||
                     (in_byte == CH_LBRACE)) begin
          if (depth_r != 8'hFF) begin
            depth_r <= depth_r + 8'd1;
          end
        end else if ((in_byte == CH_RPAREN) || (in_byte == CH_RBRACK) ||
                     (in_byte == CH_RBRACE)) begin
          if (depth_r != 8'd0) begin
            depth_r <= depth_r - 8'd1;
          end
        end
        // store, tracking first and last non-whitespace positions
        if (can_store) begin
          raw_len_r <= raw_len_r + RAW_W'(1);
          if (!is_space(in_byte)) begin
            if (!have_ns_r) begin
              first_r <= wpos;
            end
            last_ns_r <= wpos;
            have_ns_r <= 1'b1;
          end
        end else begin
          too_long_r <= 1'b1;
        end
      end
    end else if (cmd.load_char && !at_end) begin
      rd_ptr_r <= rd_ptr_r + PB_AW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_char || cmd.load_empty || cmd.load_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      out_char_r    <= rdata_r;
      char_valid_r  <= 1'b1;
      part_end_r    <= at_end;
      part_number_r <= 4'(num_r);
      string_end_r  <= 1'b0;
      part_count_r  <= 5'(cnt_r);
      last_r        <= at_end && !is_end_r;
    end else if (cmd.load_empty) begin
      out_char_r    <= 8'd0;
      char_valid_r  <= 1'b0;
      part_end_r    <= 1'b1;
      part_number_r <= 4'(num_r);
      string_end_r  <= 1'b0;
      part_count_r  <= 5'(cnt_r);
      last_r        <= !is_end_r;
    end else if (cmd.load_end) begin
      out_char_r    <= 8'd0;
      char_valid_r  <= 1'b0;
      part_end_r    <= 1'b0;
      part_number_r <= 4'd0;
      string_end_r  <= 1'b1;
      part_count_r  <= 5'(cnt_r);
      last_r        <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign char_valid  = char_valid_r;
  assign part_end    = part_end_r;
  assign part_number = part_number_r;
  assign string_end  = string_end_r;
  assign part_count  = part_count_r;
  assign last        = last_r;

endmodule

// ===== rtl/csplit_chk.sv =====
module csplit_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       char_valid,
  input logic       part_end,
  input logic       string_end,
  input logic       last
);

  // string end result is alone: no byte, no part end, always last
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_end |-> last && !char_valid && !part_end)
    else $error("string end result malformed");

  // a result without a byte must close a part or the string
  a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !char_valid |-> part_end || string_end)
    else $error("result carries nothing");

  // a closing result that is not the string end must close a part
  a_last_part: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last && !string_end |-> part_end)
    else $error("last result does not close a part");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
    else $error("stalled result changed");

endmodule

bind top_level_comma_splitter csplit_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.out_char),
  .char_valid (out_ch.char_valid),
  .part_end   (out_ch.part_end),
  .string_end (out_ch.string_end),
  .last       (out_ch.last)
);
